@@ design/ssa_pkg.sv @@
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared codes and types of the safety supervisor arbiter.
// ----------------------------------------------------------------------------
package ssa_pkg;

  // health topic slots, fixed by the 16-bit masks and the 4-bit topic index
  localparam int TOPICS = 16;

  localparam logic [2:0] ACT_TICK   = 3'd0;
  localparam logic [2:0] ACT_SAFETY = 3'd1;
  localparam logic [2:0] ACT_HEALTH = 3'd2;
  localparam logic [2:0] ACT_MGMT   = 3'd3;
  localparam logic [2:0] ACT_NET    = 3'd4;
  localparam logic [2:0] ACT_EVAL   = 3'd5;
  localparam logic [2:0] ACT_RESET  = 3'd6;

  localparam logic [2:0] MODE_UNKNOWN  = 3'd0;
  localparam logic [2:0] MODE_NORMAL   = 3'd1;
  localparam logic [2:0] MODE_HOLD     = 3'd2;
  localparam logic [2:0] MODE_FAILSAFE = 3'd3;
  localparam logic [2:0] MODE_ESTOP    = 3'd4;

  localparam logic [3:0] RSN_NONE       = 4'd0;
  localparam logic [3:0] RSN_AWAIT      = 4'd1;
  localparam logic [3:0] RSN_SAF_STALE  = 4'd2;
  localparam logic [3:0] RSN_MGMT_STALE = 4'd3;
  localparam logic [3:0] RSN_NET_BAD    = 4'd4;
  localparam logic [3:0] RSN_NET_STALE  = 4'd5;
  localparam logic [3:0] RSN_HLT_STALE  = 4'd6;
  localparam logic [3:0] RSN_OBSTACLE   = 4'd7;
  localparam logic [3:0] RSN_HLT_FAIL   = 4'd8;
  localparam logic [3:0] RSN_MAINT      = 4'd9;
  localparam logic [3:0] RSN_INACTIVE   = 4'd10;
  localparam logic [3:0] RSN_HLT_UNSAFE = 4'd11;
  localparam logic [3:0] RSN_INVALID    = 4'd12;
  localparam logic [3:0] RSN_SAF_UNK    = 4'd13;

  localparam logic [2:0] REG_SAF_TO  = 3'd0;
  localparam logic [2:0] REG_HLT_TO  = 3'd1;
  localparam logic [2:0] REG_MGMT_TO = 3'd2;
  localparam logic [2:0] REG_NET_TO  = 3'd3;
  localparam logic [2:0] REG_FS_DLY  = 3'd4;
  localparam logic [2:0] REG_REQ     = 3'd5;

  localparam logic [1:0] HC_UNKNOWN = 2'd0;
  localparam logic [1:0] HC_OK      = 2'd1;

  localparam logic [1:0] SS_UNKNOWN = 2'd0;
  localparam logic [1:0] SS_SAFE    = 2'd1;
  localparam logic [1:0] SS_UNSAFE  = 2'd2;

  localparam logic [1:0] SR_BRAKING = 2'd1;
  localparam logic [1:0] SR_HEALTH  = 2'd2;
  localparam logic [1:0] SR_INVALID = 2'd3;

  // control from sequencer to the topic scanner
  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctl_t;

  // scan results, all three counting kinds in one pass
  typedef struct packed {
    logic [4:0] wait_cnt;
    logic [3:0] wait_first;
    logic       any_fail;
    logic [4:0] fail_cnt;
    logic [3:0] fail_first;
    logic [4:0] off_cnt;
    logic [3:0] off_first;
  } scan_res_t;

endpackage

@@ design/ssa_scan.sv @@
// ----------------------------------------------------------------------------
// ssa_scan
// Walks the health table one topic per step cycle and accumulates counts.
// ----------------------------------------------------------------------------
module ssa_scan (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ssa_pkg::scan_ctl_t ctl_i,
  input  logic [3:0]         idx_i,
  input  logic               in_range_i,
  input  logic [1:0]         code_i,
  input  logic               req_i,
  input  logic               off_i,
  output ssa_pkg::scan_res_t res_o
);

  ssa_pkg::scan_res_t res_q, res_d;
  logic act, is_wait, is_fail;

  always_comb begin
    res_d   = res_q;
    act     = in_range_i && req_i;
    is_wait = code_i == ssa_pkg::HC_UNKNOWN;
    is_fail = !is_wait && code_i != ssa_pkg::HC_OK;
    if (ctl_i.clear) begin
      res_d = '0;
    end else if (ctl_i.step && act) begin
      if (off_i) begin
        if (res_q.off_cnt == 5'd0) res_d.off_first = idx_i;
        res_d.off_cnt = res_q.off_cnt + 5'd1;
      end else if (is_fail) begin
        res_d.any_fail = 1'b1;
        if (res_q.fail_cnt == 5'd0) res_d.fail_first = idx_i;
        res_d.fail_cnt = res_q.fail_cnt + 5'd1;
      end else if (is_wait) begin
        if (res_q.wait_cnt == 5'd0) res_d.wait_first = idx_i;
        res_d.wait_cnt = res_q.wait_cnt + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q.off_cnt <= 5'(ssa_pkg::TOPICS)) else $error("off count overflow");
  a_fail_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_q.fail_cnt != 5'd0) == res_q.any_fail) else $error("fail flag mismatch");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.clear |=> res_q.wait_cnt == 5'd0) else $error("clear failed");

endmodule

@@ design/safety_supervisor_arbiter.sv @@
// ----------------------------------------------------------------------------
// safety_supervisor_arbiter
// Stores safety, health, management and network reports and arbitrates mode.
// ----------------------------------------------------------------------------
// Usage: drive an event on the action_i and payload ports with start while
// busy is low. Tick, update and unused actions leave the block idle and give
// no result. Evaluate and reset-request events walk the topic table with one
// shared scan unit, one topic per cycle: the result strobe rises after the
// scan and the done state, busy high throughout. busy drops as the strobe
// rises, so a new start transfer can be taken while the strobe is high.
// A result appears for one cycle with valid_o high; the receiver cannot stall,
// so nothing is held back. Configuration writes (cfg_we_i, cfg_idx_i,
// cfg_data_i) take effect at once; the user must see that they are made while
// the block is idle, since the block itself does not enforce it.
// Reset restores register defaults, clears ages, flags, latch and health.
// ----------------------------------------------------------------------------
module safety_supervisor_arbiter #(
  parameter int AGE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action_i,
  input  logic [1:0]  safety_state_i,
  input  logic [1:0]  safety_reason_i,
  input  logic [3:0]  topic_index_i,
  input  logic [1:0]  health_code_i,
  input  logic        maintenance_flag_i,
  input  logic        mission_flag_i,
  input  logic [15:0] inactive_mask_i,
  input  logic        network_ok_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output logic        valid_o,
  output logic        reply_kind_o,
  output logic [2:0]  mode_o,
  output logic [3:0]  reason_code_o,
  output logic        command_allowed_o,
  output logic [4:0]  affected_count_o,
  output logic [3:0]  first_topic_o,
  output logic        reset_ok_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

  logic [1:0] state_q, state_d;
  logic [4:0] idx_q, idx_d;
  logic       kind_q;

  logic [15:0] saf_to_q, hlt_to_q, mgmt_to_q, net_to_q, fs_dly_q, req_q;
  logic [3:0]  seen_q;
  logic [AGE_BITS-1:0] age_q [4];
  logic [3:0]  sword_q;
  logic [1:0]  health_q [ssa_pkg::TOPICS];
  logic        link_q, maint_q, mission_q, latch_q, out_act_q;
  logic [15:0] off_q, out_ms_q;

  ssa_pkg::scan_ctl_t scan_ctl;
  ssa_pkg::scan_res_t scan_res;
  logic [3:0] sidx;
  logic       take;

  assign take = start && !busy;
  assign busy = state_q != ST_IDLE;
  assign sidx = idx_q[3:0];

  always_comb begin
    scan_ctl.clear = take;
    scan_ctl.step  = state_q == ST_SCAN;
  end

  ssa_scan u_scan (
    .clk_i, .rst_ni,
    .ctl_i      (scan_ctl),
    .idx_i      (sidx),
    .in_range_i (idx_q < 5'(ssa_pkg::TOPICS)),
    .code_i     (health_q[sidx]),
    .req_i      (req_q[sidx]),
    .off_i      (off_q[sidx]),
    .res_o      (scan_res)
  );

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (take && (action_i == ssa_pkg::ACT_EVAL || action_i == ssa_pkg::ACT_RESET)) begin
          state_d = ST_SCAN;
          idx_d   = '0;
        end
      end
      ST_SCAN: begin
        idx_d = idx_q + 5'd1;
        if (idx_q == 5'(ssa_pkg::TOPICS - 1)) state_d = ST_DONE;
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // freshness
  logic saf_f, hlt_f, mgmt_f, net_f;
  assign saf_f  = seen_q[0] && 32'(age_q[0]) <= 32'(saf_to_q);
  assign hlt_f  = seen_q[1] && 32'(age_q[1]) <= 32'(hlt_to_q);
  assign mgmt_f = seen_q[2] && 32'(age_q[2]) <= 32'(mgmt_to_q);
  assign net_f  = seen_q[3] && 32'(age_q[3]) <= 32'(net_to_q);

  logic [1:0] st, rs;
  logic [2:0] stress;
  assign st = sword_q[3:2];
  assign rs = sword_q[1:0];
  assign stress = mission_q ? ssa_pkg::MODE_FAILSAFE : ssa_pkg::MODE_HOLD;

  logic [2:0] e_mode;
  logic [3:0] e_rsn;
  logic       e_allow, e_cnt_sel, set_latch, clr_latch, start_out, end_out;
  logic [4:0] e_cnt;
  logic [3:0] e_first;
  logic       rst_ok;

  always_comb begin
    e_mode = ssa_pkg::MODE_HOLD; e_rsn = ssa_pkg::RSN_INVALID; e_allow = 1'b0;
    e_cnt = '0; e_first = '0; e_cnt_sel = 1'b0;
    set_latch = 1'b0; start_out = 1'b0; end_out = 1'b0;
    if (!seen_q[0]) begin
      e_mode = ssa_pkg::MODE_UNKNOWN; e_rsn = ssa_pkg::RSN_AWAIT;
    end else if (!saf_f) begin
      e_mode = ssa_pkg::MODE_FAILSAFE; e_rsn = ssa_pkg::RSN_SAF_STALE;
    end else if (!mgmt_f) begin
      e_mode = stress; e_rsn = ssa_pkg::RSN_MGMT_STALE;
    end else if (!(net_f && link_q)) begin
      start_out = !out_act_q;
      e_mode = (out_act_q && out_ms_q >= fs_dly_q) ? ssa_pkg::MODE_FAILSAFE
                                                   : ssa_pkg::MODE_HOLD;
      if (!out_act_q && fs_dly_q == 16'd0) e_mode = ssa_pkg::MODE_FAILSAFE;
      e_rsn = net_f ? ssa_pkg::RSN_NET_BAD : ssa_pkg::RSN_NET_STALE;
    end else begin
      end_out = 1'b1;
      if (!hlt_f) begin
        e_mode = stress; e_rsn = ssa_pkg::RSN_HLT_STALE;
      end else if (st == ssa_pkg::SS_UNSAFE && rs == ssa_pkg::SR_BRAKING) begin
        set_latch = 1'b1; e_mode = ssa_pkg::MODE_ESTOP; e_rsn = ssa_pkg::RSN_OBSTACLE;
      end else if (latch_q) begin
        e_mode = ssa_pkg::MODE_ESTOP; e_rsn = ssa_pkg::RSN_OBSTACLE;
      end else if (!scan_res.any_fail && scan_res.wait_cnt != 5'd0) begin
        e_mode = stress; e_rsn = ssa_pkg::RSN_HLT_STALE;
        e_cnt = scan_res.wait_cnt; e_first = scan_res.wait_first;
      end else if (scan_res.any_fail) begin
        e_mode = stress; e_rsn = ssa_pkg::RSN_HLT_FAIL;
        e_cnt = scan_res.fail_cnt; e_first = scan_res.fail_first;
      end else if (maint_q) begin
        e_mode = ssa_pkg::MODE_HOLD; e_rsn = ssa_pkg::RSN_MAINT;
      end else if (scan_res.off_cnt != 5'd0) begin
        e_mode = stress; e_rsn = ssa_pkg::RSN_INACTIVE;
        e_cnt = scan_res.off_cnt; e_first = scan_res.off_first;
      end else if (st == ssa_pkg::SS_UNSAFE && rs == ssa_pkg::SR_HEALTH) begin
        e_mode = stress; e_rsn = ssa_pkg::RSN_HLT_UNSAFE;
      end else if (st == ssa_pkg::SS_UNKNOWN && rs == ssa_pkg::SR_INVALID) begin
        e_rsn = ssa_pkg::RSN_INVALID;
      end else if (st == ssa_pkg::SS_UNKNOWN) begin
        e_rsn = ssa_pkg::RSN_SAF_UNK;
      end else if (st == ssa_pkg::SS_SAFE) begin
        e_mode = ssa_pkg::MODE_NORMAL; e_rsn = ssa_pkg::RSN_NONE; e_allow = 1'b1;
      end
    end
    e_cnt_sel = e_cnt != 5'd0;
    rst_ok = !latch_q || (saf_f && hlt_f && net_f && link_q && st == ssa_pkg::SS_SAFE &&
             !maint_q && scan_res.off_cnt == 5'd0 && !scan_res.any_fail);
    clr_latch = latch_q && rst_ok;
  end

  logic done;
  assign done = state_q == ST_DONE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; idx_q <= '0; kind_q <= 1'b0;
      saf_to_q <= 16'd500; hlt_to_q <= 16'd1500; mgmt_to_q <= 16'd1500;
      net_to_q <= 16'd3000; fs_dly_q <= 16'd10000; req_q <= 16'd1;
      seen_q <= '0; sword_q <= '0; link_q <= 1'b0; maint_q <= 1'b0;
      mission_q <= 1'b0; off_q <= '0; latch_q <= 1'b0; out_act_q <= 1'b0;
      out_ms_q <= '0;
      for (int i = 0; i < 4; i++) age_q[i] <= '0;
      for (int i = 0; i < ssa_pkg::TOPICS; i++) health_q[i] <= '0;
      valid_o <= 1'b0; reply_kind_o <= 1'b0; mode_o <= '0; reason_code_o <= '0;
      command_allowed_o <= 1'b0; affected_count_o <= '0; first_topic_o <= '0;
      reset_ok_o <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      valid_o <= done;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ssa_pkg::REG_SAF_TO:  saf_to_q  <= cfg_data_i;
          ssa_pkg::REG_HLT_TO:  hlt_to_q  <= cfg_data_i;
          ssa_pkg::REG_MGMT_TO: mgmt_to_q <= cfg_data_i;
          ssa_pkg::REG_NET_TO:  net_to_q  <= cfg_data_i;
          ssa_pkg::REG_FS_DLY:  fs_dly_q  <= cfg_data_i;
          ssa_pkg::REG_REQ:     req_q     <= cfg_data_i;
          default: ;
        endcase
      end
      if (take) begin
        kind_q <= action_i == ssa_pkg::ACT_RESET;
        case (action_i)
          ssa_pkg::ACT_TICK: begin
            for (int i = 0; i < 4; i++)
              if (age_q[i] != AGE_MAX) age_q[i] <= age_q[i] + AGE_BITS'(1);
            if (out_act_q && out_ms_q != 16'hFFFF) out_ms_q <= out_ms_q + 16'd1;
          end
          ssa_pkg::ACT_SAFETY: begin
            sword_q <= {safety_state_i, safety_reason_i};
            seen_q[0] <= 1'b1; age_q[0] <= '0;
          end
          ssa_pkg::ACT_HEALTH: begin
            seen_q[1] <= 1'b1; age_q[1] <= '0;
            health_q[topic_index_i] <= health_code_i;
          end
          ssa_pkg::ACT_MGMT: begin
            seen_q[2] <= 1'b1; age_q[2] <= '0;
            maint_q <= maintenance_flag_i; mission_q <= mission_flag_i;
            off_q <= inactive_mask_i;
          end
          ssa_pkg::ACT_NET: begin
            seen_q[3] <= 1'b1; age_q[3] <= '0;
            link_q <= network_ok_i;
          end
          default: ;
        endcase
      end
      if (done) begin
        reply_kind_o <= kind_q;
        if (kind_q) begin
          mode_o <= '0; reason_code_o <= '0; command_allowed_o <= 1'b0;
          affected_count_o <= '0; first_topic_o <= '0; reset_ok_o <= rst_ok;
          if (clr_latch) latch_q <= 1'b0;
        end else begin
          mode_o <= e_mode; reason_code_o <= e_rsn; command_allowed_o <= e_allow;
          affected_count_o <= e_cnt; first_topic_o <= e_cnt_sel ? e_first : 4'd0;
          reset_ok_o <= 1'b0;
          if (set_latch) latch_q <= 1'b1;
          if (start_out) begin
            out_act_q <= 1'b1; out_ms_q <= '0;
          end
          if (end_out) begin
            out_act_q <= 1'b0; out_ms_q <= '0;
          end
        end
      end
    end
  end

  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(state_q) == ST_DONE) else $error("stray result");
  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> busy) else $error("idle while scanning");
  a_ok_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !reply_kind_o) |-> !reset_ok_o) else $error("reset_ok on status");

endmodule

@@ bench/safety_supervisor_arbiter_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// safety_supervisor_arbiter_checker
// Watches the event, register and result ports of the supervisor arbiter,
// keeps its own copy of the supervisor state, predicts every status and
// reset reply and compares them with what the block puts out.
// ----------------------------------------------------------------------------
module safety_supervisor_arbiter_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  action_i,
  input  logic [1:0]  safety_state_i,
  input  logic [1:0]  safety_reason_i,
  input  logic [3:0]  topic_index_i,
  input  logic [1:0]  health_code_i,
  input  logic        maintenance_flag_i,
  input  logic        mission_flag_i,
  input  logic [15:0] inactive_mask_i,
  input  logic        network_ok_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        valid_o,
  input  logic        reply_kind_o,
  input  logic [2:0]  mode_o,
  input  logic [3:0]  reason_code_o,
  input  logic        command_allowed_o,
  input  logic [4:0]  affected_count_o,
  input  logic [3:0]  first_topic_o,
  input  logic        reset_ok_o,
  output int          pending_o,
  output int          errors_o
);

  localparam int SRC_SAF  = 0;
  localparam int SRC_HLT  = 1;
  localparam int SRC_MGMT = 2;
  localparam int SRC_NET  = 3;

  localparam int CNT_WAIT = 0;
  localparam int CNT_FAIL = 1;
  localparam int CNT_OFF  = 2;

  typedef struct packed {
    logic       kind;
    logic [2:0] mode;
    logic [3:0] reason;
    logic       allowed;
    logic [4:0] cnt;
    logic [3:0] first;
    logic       ok;
  } verdict_t;

  logic [15:0] saf_to, hlt_to, mgmt_to, net_to, fs_dly, req_mask;
  logic [3:0]  seen;
  logic [15:0] age [4];
  logic [1:0]  saf_state, saf_reason;
  logic [1:0]  health [16];
  logic        link_up, maint, mission, latch, outage;
  logic [15:0] off_mask, outage_ms;

  verdict_t verdict_q[$];

  function automatic logic fresh(int src, logic [15:0] limit);
    return seen[src] && (age[src] <= limit);
  endfunction

  // count required topics of one kind; waiting count collapses to zero once
  // any active required topic has failed
  function automatic logic [4:0] topic_tally(int kind, output logic [3:0] first);
    logic [4:0] n;
    logic hit;
    n = '0;
    first = '0;
    for (int i = 0; i < 16; i++) begin
      if (!req_mask[i]) continue;
      if (kind == CNT_OFF) begin
        hit = off_mask[i];
      end else begin
        if (off_mask[i]) continue;
        if (kind == CNT_WAIT) begin
          if (health[i] != ssa_pkg::HC_UNKNOWN && health[i] != ssa_pkg::HC_OK) begin
            first = '0;
            return '0;
          end
          hit = (health[i] == ssa_pkg::HC_UNKNOWN);
        end else begin
          hit = (health[i] != ssa_pkg::HC_UNKNOWN && health[i] != ssa_pkg::HC_OK);
        end
      end
      if (hit) begin
        if (n == 0) first = i[3:0];
        n++;
      end
    end
    return n;
  endfunction

  function automatic verdict_t status_of(logic [2:0] mode, logic [3:0] reason,
                                         logic [4:0] cnt, logic [3:0] first);
    verdict_t v;
    v = '0;
    v.mode = mode;
    v.reason = reason;
    v.allowed = (mode == ssa_pkg::MODE_NORMAL);
    v.cnt = cnt;
    v.first = first;
    return v;
  endfunction

  function automatic verdict_t arbitrate();
    logic [2:0] stress;
    logic [3:0] first;
    logic [4:0] n;
    logic       net_fresh;
    stress = mission ? ssa_pkg::MODE_FAILSAFE : ssa_pkg::MODE_HOLD;
    if (!seen[SRC_SAF]) return status_of(ssa_pkg::MODE_UNKNOWN, ssa_pkg::RSN_AWAIT, 0, 0);
    if (!fresh(SRC_SAF, saf_to))
      return status_of(ssa_pkg::MODE_FAILSAFE, ssa_pkg::RSN_SAF_STALE, 0, 0);
    if (!fresh(SRC_MGMT, mgmt_to)) return status_of(stress, ssa_pkg::RSN_MGMT_STALE, 0, 0);
    net_fresh = fresh(SRC_NET, net_to);
    if (!(net_fresh && link_up)) begin
      if (!outage) begin
        outage = 1'b1;
        outage_ms = '0;
      end
      return status_of((outage_ms >= fs_dly) ? ssa_pkg::MODE_FAILSAFE : ssa_pkg::MODE_HOLD,
                       net_fresh ? ssa_pkg::RSN_NET_BAD : ssa_pkg::RSN_NET_STALE, 0, 0);
    end
    outage = 1'b0;
    outage_ms = '0;
    if (!fresh(SRC_HLT, hlt_to)) return status_of(stress, ssa_pkg::RSN_HLT_STALE, 0, 0);
    if (saf_state == ssa_pkg::SS_UNSAFE && saf_reason == ssa_pkg::SR_BRAKING) latch = 1'b1;
    if (latch) return status_of(ssa_pkg::MODE_ESTOP, ssa_pkg::RSN_OBSTACLE, 0, 0);
    n = topic_tally(CNT_WAIT, first);
    if (n != 0) return status_of(stress, ssa_pkg::RSN_HLT_STALE, n, first);
    n = topic_tally(CNT_FAIL, first);
    if (n != 0) return status_of(stress, ssa_pkg::RSN_HLT_FAIL, n, first);
    if (maint) return status_of(ssa_pkg::MODE_HOLD, ssa_pkg::RSN_MAINT, 0, 0);
    n = topic_tally(CNT_OFF, first);
    if (n != 0) return status_of(stress, ssa_pkg::RSN_INACTIVE, n, first);
    if (saf_state == ssa_pkg::SS_UNSAFE && saf_reason == ssa_pkg::SR_HEALTH)
      return status_of(stress, ssa_pkg::RSN_HLT_UNSAFE, 0, 0);
    if (saf_state == ssa_pkg::SS_UNKNOWN && saf_reason == ssa_pkg::SR_INVALID)
      return status_of(ssa_pkg::MODE_HOLD, ssa_pkg::RSN_INVALID, 0, 0);
    if (saf_state == ssa_pkg::SS_UNKNOWN)
      return status_of(ssa_pkg::MODE_HOLD, ssa_pkg::RSN_SAF_UNK, 0, 0);
    if (saf_state == ssa_pkg::SS_SAFE)
      return status_of(ssa_pkg::MODE_NORMAL, ssa_pkg::RSN_NONE, 0, 0);
    return status_of(ssa_pkg::MODE_HOLD, ssa_pkg::RSN_INVALID, 0, 0);
  endfunction

  function automatic verdict_t latch_release();
    verdict_t v;
    logic [3:0] first;
    logic reject;
    v = '0;
    v.kind = 1'b1;
    if (!latch) begin
      v.ok = 1'b1;
      return v;
    end
    reject = !fresh(SRC_SAF, saf_to) || !fresh(SRC_HLT, hlt_to) || !fresh(SRC_NET, net_to)
          || !link_up || saf_state != ssa_pkg::SS_SAFE || maint
          || topic_tally(CNT_OFF, first) != 0 || topic_tally(CNT_FAIL, first) != 0;
    if (!reject) latch = 1'b0;
    v.ok = !reject;
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t got, want;
    if (!rst_ni) begin
      saf_to = 16'd500;
      hlt_to = 16'd1500;
      mgmt_to = 16'd1500;
      net_to = 16'd3000;
      fs_dly = 16'd10000;
      req_mask = 16'd1;
      seen = '0;
      for (int i = 0; i < 4; i++) age[i] = '0;
      for (int i = 0; i < 16; i++) health[i] = ssa_pkg::HC_UNKNOWN;
      saf_state = ssa_pkg::SS_UNKNOWN;
      saf_reason = '0;
      link_up = 1'b0;
      maint = 1'b0;
      mission = 1'b0;
      off_mask = '0;
      latch = 1'b0;
      outage = 1'b0;
      outage_ms = '0;
      verdict_q.delete();
      errors_o = 0;
    end else begin
      if (valid_o) begin
        got = '{reply_kind_o, mode_o, reason_code_o, command_allowed_o,
                affected_count_o, first_topic_o, reset_ok_o};
        if (verdict_q.size() == 0) begin
          if (errors_o < 10) $display("unexpected result at %0t: %p", $realtime, got);
          errors_o++;
        end else begin
          want = verdict_q.pop_front();
          if (got !== want) begin
            if (errors_o < 10) $display("mismatch at %0t: expected %p, got %p",
                                        $realtime, want, got);
            errors_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ssa_pkg::REG_SAF_TO:  saf_to = cfg_data_i;
          ssa_pkg::REG_HLT_TO:  hlt_to = cfg_data_i;
          ssa_pkg::REG_MGMT_TO: mgmt_to = cfg_data_i;
          ssa_pkg::REG_NET_TO:  net_to = cfg_data_i;
          ssa_pkg::REG_FS_DLY:  fs_dly = cfg_data_i;
          ssa_pkg::REG_REQ:     req_mask = cfg_data_i;
          default: ;
        endcase
      end
      if (start && !busy) begin
        case (action_i)
          ssa_pkg::ACT_TICK: begin
            for (int i = 0; i < 4; i++) if (age[i] != 16'hFFFF) age[i]++;
            if (outage && outage_ms != 16'hFFFF) outage_ms++;
          end
          ssa_pkg::ACT_SAFETY: begin
            saf_state = safety_state_i;
            saf_reason = safety_reason_i;
            seen[SRC_SAF] = 1'b1;
            age[SRC_SAF] = '0;
          end
          ssa_pkg::ACT_HEALTH: begin
            seen[SRC_HLT] = 1'b1;
            age[SRC_HLT] = '0;
            health[topic_index_i] = health_code_i;
          end
          ssa_pkg::ACT_MGMT: begin
            seen[SRC_MGMT] = 1'b1;
            age[SRC_MGMT] = '0;
            maint = maintenance_flag_i;
            mission = mission_flag_i;
            off_mask = inactive_mask_i;
          end
          ssa_pkg::ACT_NET: begin
            seen[SRC_NET] = 1'b1;
            age[SRC_NET] = '0;
            link_up = network_ok_i;
          end
          ssa_pkg::ACT_EVAL:  verdict_q.push_back(arbitrate());
          ssa_pkg::ACT_RESET: verdict_q.push_back(latch_release());
          default: ;
        endcase
      end
    end
    pending_o = verdict_q.size();
  end

endmodule

@@ bench/safety_supervisor_arbiter_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// safety_supervisor_arbiter_test
// Drives directed and random event streams into the supervisor arbiter over
// several register settings and idle patterns; the checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module safety_supervisor_arbiter_test;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [2:0]  action;
    logic [1:0]  saf_state;
    logic [1:0]  saf_reason;
    logic [3:0]  topic;
    logic [1:0]  hcode;
    logic        maint;
    logic        mission;
    logic [15:0] off_mask;
    logic        net_ok;
  } event_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  action_i = '0;
  logic [1:0]  safety_state_i = '0;
  logic [1:0]  safety_reason_i = '0;
  logic [3:0]  topic_index_i = '0;
  logic [1:0]  health_code_i = '0;
  logic        maintenance_flag_i = 1'b0;
  logic        mission_flag_i = 1'b0;
  logic [15:0] inactive_mask_i = '0;
  logic        network_ok_i = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        valid_o, reply_kind_o, command_allowed_o, reset_ok_o;
  logic [2:0]  mode_o;
  logic [3:0]  reason_code_o, first_topic_o;
  logic [4:0]  affected_count_o;
  int          pending, errors;
  int          cycles = 0;
  int          idle_pct = 0;

  safety_supervisor_arbiter u_top (.*);

  safety_supervisor_arbiter_checker u_chk (.*, .pending_o(pending), .errors_o(errors));

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic event_t mk(logic [2:0] act, logic [1:0] st = ssa_pkg::SS_SAFE,
                                logic [1:0] rs = '0, logic [3:0] topic = '0,
                                logic [1:0] hc = ssa_pkg::HC_OK, logic mt = 1'b0,
                                logic ms = 1'b0, logic [15:0] off = '0,
                                logic nok = 1'b1);
    event_t e;
    e = '{act, st, rs, topic, hc, mt, ms, off, nok};
    return e;
  endfunction

  // mostly well-formed updates with random content, a little noise
  function automatic event_t rand_event();
    event_t e;
    int w;
    w = $urandom_range(99);
    e.action = (w < 30) ? ssa_pkg::ACT_TICK : (w < 42) ? ssa_pkg::ACT_SAFETY :
               (w < 56) ? ssa_pkg::ACT_HEALTH : (w < 64) ? ssa_pkg::ACT_MGMT :
               (w < 72) ? ssa_pkg::ACT_NET : (w < 92) ? ssa_pkg::ACT_EVAL :
               (w < 98) ? ssa_pkg::ACT_RESET : 3'd7;
    e.saf_state = ($urandom_range(99) < 70) ? ssa_pkg::SS_SAFE : 2'($urandom);
    e.saf_reason = 2'($urandom);
    e.topic = 4'($urandom);
    e.hcode = ($urandom_range(99) < 75) ? ssa_pkg::HC_OK : 2'($urandom);
    e.maint = ($urandom_range(99) < 10);
    e.mission = ($urandom_range(99) < 30);
    e.off_mask = ($urandom_range(99) < 80) ? 16'h0 : 16'($urandom);
    e.net_ok = ($urandom_range(99) < 85);
    return e;
  endfunction

  // called at a rising edge; returns at or after the transfer edge
  task automatic send(event_t e);
    action_i <= e.action;
    safety_state_i <= e.saf_state;
    safety_reason_i <= e.saf_reason;
    topic_index_i <= e.topic;
    health_code_i <= e.hcode;
    maintenance_flag_i <= e.maint;
    mission_flag_i <= e.mission;
    inactive_mask_i <= e.off_mask;
    network_ok_i <= e.net_ok;
    start <= 1'b1;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (25) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [15:0] saf, logic [15:0] hlt, logic [15:0] mgmt,
                            logic [15:0] net, logic [15:0] dly, logic [15:0] req);
    logic [15:0] vals [6];
    vals = '{saf, hlt, mgmt, net, dly, req};
    for (int i = 0; i < 6; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= 3'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_random(int n, int pct);
    idle_pct = pct;
    repeat (n) send(rand_event());
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // walk down the priority chain with the default registers
    send(mk(ssa_pkg::ACT_EVAL));
    send(mk(ssa_pkg::ACT_RESET));
    send(mk(3'd7));
    send(mk(ssa_pkg::ACT_SAFETY, ssa_pkg::SS_SAFE));
    send(mk(ssa_pkg::ACT_EVAL));
    send(mk(ssa_pkg::ACT_MGMT));
    send(mk(ssa_pkg::ACT_NET, .nok(1'b0)));
    send(mk(ssa_pkg::ACT_EVAL));
    send(mk(ssa_pkg::ACT_NET));
    send(mk(ssa_pkg::ACT_EVAL));
    send(mk(ssa_pkg::ACT_HEALTH, .topic(4'd0), .hc(2'd3)));
    send(mk(ssa_pkg::ACT_EVAL));
    send(mk(ssa_pkg::ACT_HEALTH, .topic(4'd0), .hc(ssa_pkg::HC_OK)));
    send(mk(ssa_pkg::ACT_EVAL));
    send(mk(ssa_pkg::ACT_MGMT, .mt(1'b1)));
    send(mk(ssa_pkg::ACT_EVAL));
    send(mk(ssa_pkg::ACT_MGMT, .ms(1'b1), .off(16'hFFFF)));
    send(mk(ssa_pkg::ACT_EVAL));
    send(mk(ssa_pkg::ACT_MGMT));
    send(mk(ssa_pkg::ACT_SAFETY, ssa_pkg::SS_UNSAFE, ssa_pkg::SR_BRAKING));
    send(mk(ssa_pkg::ACT_EVAL));
    send(mk(ssa_pkg::ACT_RESET));
    send(mk(ssa_pkg::ACT_SAFETY, ssa_pkg::SS_SAFE, 2'd3));
    send(mk(ssa_pkg::ACT_RESET));
    send(mk(ssa_pkg::ACT_SAFETY, 2'd3, ssa_pkg::SR_HEALTH));
    send(mk(ssa_pkg::ACT_EVAL));
    drain();

    write_regs(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'hFFFF);
    run_random(100, 0);
    write_regs(16'd60000, 16'd60000, 16'd60000, 16'd60000, 16'd60000, 16'd1);
    run_random(80, 60);
    for (int p = 0; p < 4; p++) begin
      write_regs(16'($urandom_range(2, 40)), 16'($urandom_range(2, 40)),
                 16'($urandom_range(2, 40)), 16'($urandom_range(2, 40)),
                 16'($urandom_range(1, 30)),
                 (p == 0) ? 16'hFFFF : 16'($urandom_range(1, 65535)));
      run_random(80, (p == 1) ? 60 : (p == 2) ? 0 : 34);
    end

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
